>>> design/set_assoc_cache_lru_sim_assert.svh
// Assertion macros used by the cache tag model RTL.
`ifndef SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define SALRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock and idle during reset.
`define SALRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/salru_pkg.sv
// Types and constants of the set-associative LRU cache tag model.
package salru_pkg;

  // Fixed field widths.
  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 64;
  localparam int RANK_W   = 3;
  localparam int CNT_W    = 32;
  localparam int SB_W     = 3;
  localparam int SB_EFF_W = 4;
  localparam int BB_W     = 6;
  localparam int WAYS_W   = 4;
  localparam int NW_W     = 5;
  localparam int SHIFT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // Access kinds; the unused code behaves as a load.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } op_e;

  // Result of the first lookup of an access.
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  // One way of a set: valid flag, tag and recency rank (0 is most recent).
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

endpackage

>>> design/salru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module salru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache tag model with LRU replacement.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | op_i, addr_i
//  out     | output    | out_valid_o / out_stall_i | outcome_o, hit_total_o, miss_total_o,
//          |           |                        | evict_total_o
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One word is accepted every cycle unless a stalled result holds the lookup stage; its result
// is offered once the word leaves that stage. The set row is read from the tag RAM at the
// accepting edge, and lookup, replacement and write-back load the result register as it leaves.
// A word that follows one to the same set gets the freshly written row through a bypass.
// Reset clears per-set valid flags in flip-flops, so no clearing pass runs after reset.
// A stalled result holds the lookup stage; the input stalls only when that stage is full.
`include "set_assoc_cache_lru_sim_assert.svh"

module set_assoc_cache_lru_sim
  import salru_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Access channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [ADDR_W-1:0]     addr_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            outcome_o,
  output logic [CNT_W-1:0]      hit_total_o,
  output logic [CNT_W-1:0]      miss_total_o,
  output logic [CNT_W-1:0]      evict_total_o
);

  localparam int SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NumSets = 1 << MAX_SET_BITS;
  localparam int WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RowW    = MAX_WAYS * $bits(line_t);

  // Configuration registers
  logic [SB_W-1:0]   set_bits_q;
  logic [BB_W-1:0]   block_bits_q;
  logic [WAYS_W-1:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= WAYS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_data_i[SB_W-1:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[BB_W-1:0];
        CFG_WAYS:       ways_q       <= cfg_data_i[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: clamp set bits and way count to what is built.
  logic [SB_EFF_W-1:0] sb_eff;
  logic [NW_W-1:0]     nw;
  logic [SHIFT_W-1:0]  shift_amt;

  always_comb begin
    if ({1'b0, set_bits_q} > SB_EFF_W'(MAX_SET_BITS)) begin
      sb_eff = SB_EFF_W'(MAX_SET_BITS);
    end else begin
      sb_eff = {1'b0, set_bits_q};
    end
    if (ways_q == '0) begin
      nw = NW_W'(1);
    end else if ({1'b0, ways_q} > NW_W'(MAX_WAYS)) begin
      nw = NW_W'(MAX_WAYS);
    end else begin
      nw = {1'b0, ways_q};
    end
    shift_amt = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_q);
  end

  // Address split of the incoming word into set index and tag.
  logic [ADDR_W-1:0] blk_addr;
  logic [SetW:0]     set_one;
  logic [SetW-1:0]   set_mask;
  logic [SetW-1:0]   in_set;
  logic [TAG_W-1:0]  in_tag;

  always_comb begin
    blk_addr = addr_i >> block_bits_q;
    set_one  = (SetW + 1)'(1) << sb_eff;
    set_mask = SetW'(set_one - (SetW + 1)'(1));
    in_set   = blk_addr[SetW-1:0] & set_mask;
    if (shift_amt >= SHIFT_W'(ADDR_W)) begin
      in_tag = '0;
    end else begin
      in_tag = addr_i >> shift_amt[5:0];
    end
  end

  // Pipeline handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;
  logic in_accept;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Lookup stage registers
  logic [SetW-1:0]  s1_set_q;
  logic [TAG_W-1:0] s1_tag_q;
  logic             s1_mod_q;
  logic             s1_rowv_q;
  logic             s1_byp_q;
  logic [RowW-1:0]  byp_row_q;
  logic [NumSets-1:0] row_valid_q;

  logic             same_set;
  line_t [MAX_WAYS-1:0] new_row;

  assign same_set = s1_fire && (s1_set_q == in_set);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      row_valid_q <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        row_valid_q[s1_set_q] <= 1'b1;
      end
    end
  end

  // Word payload and bypass of a row written at the same edge as its read.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_set_q  <= in_set;
      s1_tag_q  <= in_tag;
      s1_mod_q  <= (op_i == OP_MODIFY);
      s1_rowv_q <= row_valid_q[in_set] || same_set;
      s1_byp_q  <= same_set;
      byp_row_q <= new_row;
    end
  end

  // Tag RAM: one row per set holding every way.
  logic [RowW-1:0] ram_rdata;

  salru_ram #(
    .Width (RowW),
    .Depth (NumSets)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_set_q),
    .wdata_i (new_row),
    .re_i    (in_accept),
    .raddr_i (in_set),
    .rdata_o (ram_rdata)
  );

  line_t [MAX_WAYS-1:0] cur_row;

  always_comb begin
    if (s1_byp_q) begin
      cur_row = byp_row_q;
    end else if (s1_rowv_q) begin
      cur_row = ram_rdata;
    end else begin
      cur_row = '0;
    end
  end

  // Lookup, way selection and recency update of the current set.
  logic [MAX_WAYS-1:0] inuse;
  logic [MAX_WAYS-1:0] match;
  logic                hit;
  logic [WayW-1:0]     hit_way;
  logic                free_any;
  logic [WayW-1:0]     free_way;
  logic [WayW-1:0]     vic_way;
  logic [RANK_W-1:0]   best_rank;
  logic                vic_found;
  logic [WayW-1:0]     tgt_way;
  logic [RANK_W-1:0]   old_rank;
  logic                is_fill;
  logic [1:0]          outcome;

  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    free_any  = 1'b0;
    free_way  = '0;
    vic_way   = '0;
    best_rank = '0;
    vic_found = 1'b0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      inuse[w] = (NW_W'(w) < nw);
      match[w] = inuse[w] && cur_row[w].valid && (cur_row[w].tag == s1_tag_q);
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
      if (inuse[w] && !cur_row[w].valid) begin
        free_any = 1'b1;
        free_way = WayW'(w);
      end
    end
    // Victim: highest rank, lowest way on ties.
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (inuse[w] && (!vic_found || (cur_row[w].rank > best_rank))) begin
        best_rank = cur_row[w].rank;
        vic_way   = WayW'(w);
        vic_found = 1'b1;
      end
    end
    if (hit) begin
      tgt_way = hit_way;
    end else if (free_any) begin
      tgt_way = free_way;
    end else begin
      tgt_way = vic_way;
    end
    is_fill  = !hit && free_any;
    old_rank = cur_row[tgt_way].rank;
    if (hit) begin
      outcome = OUT_HIT;
    end else if (is_fill) begin
      outcome = OUT_FILL;
    end else begin
      outcome = OUT_EVICT;
    end
    // Age the other valid ways that were more recent (all of them on a fill), then promote the target.
    new_row = cur_row;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (inuse[v] && (WayW'(v) != tgt_way) && cur_row[v].valid &&
          (is_fill || (cur_row[v].rank < old_rank)) && (cur_row[v].rank != RANK_MAX)) begin
        new_row[v].rank = cur_row[v].rank + RANK_W'(1);
      end
    end
    new_row[tgt_way].rank = '0;
    if (!hit) begin
      new_row[tgt_way].valid = 1'b1;
      new_row[tgt_way].tag   = s1_tag_q;
    end
  end

  // Saturating counters; a modify adds a second hit.
  logic [CNT_W-1:0] hits_q, misses_q, evict_q;
  logic [CNT_W-1:0] hits_d, misses_d, evict_d;
  logic [CNT_W:0]   hit_sum;
  logic [1:0]       hit_inc;

  always_comb begin
    hit_inc = {1'b0, hit} + {1'b0, s1_mod_q};
    hit_sum = {1'b0, hits_q} + (CNT_W + 1)'(hit_inc);
    hits_d  = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    misses_d = misses_q;
    evict_d  = evict_q;
    if (!hit && (misses_q != '1)) begin
      misses_d = misses_q + CNT_W'(1);
    end
    if (!hit && !free_any && (evict_q != '1)) begin
      evict_d = evict_q + CNT_W'(1);
    end
  end

  logic [1:0] outcome_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evict_q     <= evict_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word outcome; the totals come straight from the counters.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      outcome_q <= outcome;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign hit_total_o   = hits_q;
  assign miss_total_o  = misses_q;
  assign evict_total_o = evict_q;

  // Checks on counters and lookup results.
  `SALRU_ASSERT_NOW(a_evict_le_miss, 1'b1, evict_q <= misses_q, "evictions exceed misses")
  `SALRU_ASSERT_NEXT(a_hit_counted, s1_fire && hit, (hits_q != $past(hits_q)) || ($past(hits_q) == '1), "hit not counted")
  `SALRU_ASSERT_NEXT(a_stall_holds_stage, s1_valid_q && out_valid_q && out_stall_i, s1_valid_q && $stable(s1_set_q) && $stable(hits_q), "lookup stage moved under stall")

endmodule

>>> tb/tb.sv
// Testbench for the set-associative LRU cache tag model: directed and random accesses.
`timescale 1ns / 100ps

module tb;
  import salru_pkg::*;

  localparam int SETS_LOG2 = 6;
  localparam int WAY_COUNT = 8;
  localparam int LINES = (1 << SETS_LOG2) * WAY_COUNT;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 100;
  localparam int HOLD_CYCLES = 80;
  localparam int TAG_POOL = 12;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_e;

  // One line of the directed script: an access or a register write.
  typedef struct packed {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            op;
    logic [ADDR_W-1:0]     addr;
    logic                  typed;
    outcome_e              outcome;
    logic [CNT_W-1:0]      hits, misses, evicts;
  } row_t;

  typedef struct packed {
    outcome_e         outcome;
    logic [CNT_W-1:0] hits, misses, evicts;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            op_i = '0;
  logic [ADDR_W-1:0]     addr_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            outcome_o;
  logic [CNT_W-1:0]      hit_total_o;
  logic [CNT_W-1:0]      miss_total_o;
  logic [CNT_W-1:0]      evict_total_o;

  set_assoc_cache_lru_sim #(
    .MAX_SET_BITS(SETS_LOG2),
    .MAX_WAYS    (WAY_COUNT)
  ) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .addr_i,
    .out_valid_o, .out_stall_i, .outcome_o, .hit_total_o, .miss_total_o, .evict_total_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the cache tags, recency ranks, counters and geometry.
  logic             shadow_valid [LINES];
  logic [TAG_W-1:0] shadow_tag [LINES];
  logic [RANK_W-1:0] shadow_rank [LINES];
  logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [2:0]       set_bits_m;
  logic [5:0]       block_bits_m;
  logic [3:0]       ways_m;

  result_t pending_results [$];
  result_t due;
  int      mismatches = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;

  // Directed script: reset behavior with one set and one way, every op, odd geometries.
  row_t script [0:24] = '{
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h0, 1'b1, OUT_FILL, 32'd0, 32'd1, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h0, 1'b1, OUT_HIT, 32'd1, 32'd1, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_STORE, '1, 1'b1, OUT_EVICT, 32'd1, 32'd2, 32'd1},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_MODIFY, 64'h5, 1'b1, OUT_EVICT, 32'd2, 32'd3, 32'd2},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_UNUSED, 64'h5, 1'b1, OUT_HIT, 32'd3, 32'd3, 32'd2},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_UNUSED, 64'h0, 1'b1, OUT_EVICT, 32'd3, 32'd4, 32'd3},
    '{ROW_WRITE, CFG_WAYS, 6'd0, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_SET_BITS, 6'h3f, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_BLOCK_BITS, 6'd63, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_STORE, 64'h8000_0000_0000_0000, 1'b0, OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_MODIFY, 64'h8000_0000_0000_0001, 1'b0, OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_WAYS, 6'd15, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_BLOCK_BITS, 6'd58, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'hfc00_0000_0000_0000, 1'b0, OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h0400_0000_0000_0000, 1'b0, OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_BLOCK_BITS, 6'd4, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_SET_BITS, 6'd1, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_WRITE, CFG_WAYS, 6'd2, OP_LOAD, 64'h0, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h20, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h40, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_STORE, 64'h2f, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h60, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_MODIFY, 64'h10, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{ROW_ACCESS, CFG_WAYS, 6'd0, OP_LOAD, 64'h45, 1'b0, OUT_HIT, 32'd0, 32'd0, 32'd0}
  };

  // Effective geometry: oversized set counts and way counts are clamped.
  function automatic int sets_log2_in_use();
    return (set_bits_m > SETS_LOG2) ? SETS_LOG2 : int'(set_bits_m);
  endfunction

  function automatic int ways_in_use();
    if (ways_m == 0) return 1;
    if (ways_m > WAY_COUNT) return WAY_COUNT;
    return int'(ways_m);
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Make one way the most recent; younger valid ways (all of them on a fill) age by one.
  function automatic void promote(int base, int w, int nw, bit fill);
    logic [RANK_W-1:0] old;
    int v;
    old = shadow_rank[base + w];
    for (v = 0; v < nw; v++) begin
      if (v != w && shadow_valid[base + v] && (fill || shadow_rank[base + v] < old)) begin
        if (shadow_rank[base + v] < RANK_MAX) shadow_rank[base + v]++;
      end
    end
    shadow_rank[base + w] = '0;
  endfunction

  // One tag lookup with fill or LRU eviction on a miss.
  function automatic outcome_e tag_lookup(logic [ADDR_W-1:0] a);
    int sb, nw, shift, base, w, victim;
    logic [TAG_W-1:0] tg;
    logic [RANK_W-1:0] best;
    bit found;
    sb = sets_log2_in_use();
    nw = ways_in_use();
    shift = sb + int'(block_bits_m);
    tg = (shift >= 64) ? '0 : a >> shift;
    base = int'((a >> block_bits_m) & ((64'd1 << sb) - 64'd1)) * WAY_COUNT;
    for (w = 0; w < nw; w++) begin
      if (shadow_valid[base + w] && shadow_tag[base + w] == tg) begin
        hit_cnt = bump(hit_cnt);
        promote(base, w, nw, 1'b0);
        return OUT_HIT;
      end
    end
    miss_cnt = bump(miss_cnt);
    for (w = 0; w < nw; w++) begin
      if (!shadow_valid[base + w]) begin
        shadow_valid[base + w] = 1'b1;
        shadow_tag[base + w] = tg;
        promote(base, w, nw, 1'b1);
        return OUT_FILL;
      end
    end
    found = 1'b0;
    best = '0;
    victim = 0;
    for (w = 0; w < nw; w++) begin
      if (!found || shadow_rank[base + w] > best) begin
        best = shadow_rank[base + w];
        victim = w;
        found = 1'b1;
      end
    end
    evict_cnt = bump(evict_cnt);
    shadow_tag[base + victim] = tg;
    promote(base, victim, nw, 1'b0);
    return OUT_EVICT;
  endfunction

  // A modify does a second lookup that only refreshes recency and counts a hit.
  function automatic result_t predict_access(logic [1:0] op, logic [ADDR_W-1:0] a);
    result_t r;
    r.outcome = tag_lookup(a);
    if (op == OP_MODIFY) void'(tag_lookup(a));
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    return r;
  endfunction

  task automatic mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Offer one word, with random gaps, and record its expected result once it is taken.
  task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                             input bit typed, input result_t typed_res);
    result_t r;
    while (!quiet && $urandom_range(0, 99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    addr_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = predict_access(op, a);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Stop offering words and wait until the block has drained.
  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SET_BITS: set_bits_m = d[2:0];
      CFG_BLOCK_BITS: block_bits_m = d;
      CFG_WAYS: ways_m = d[3:0];
      default: ;
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 30);
        @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch("result with no access outstanding");
      end else begin
        due = pending_results.pop_front();
        if (outcome_o != due.outcome)
          mismatch($sformatf("outcome %0d, want %0d", outcome_o, due.outcome));
        if (hit_total_o != due.hits)
          mismatch($sformatf("hit_total %0d, want %0d", hit_total_o, due.hits));
        if (miss_total_o != due.misses)
          mismatch($sformatf("miss_total %0d, want %0d", miss_total_o, due.misses));
        if (evict_total_o != due.evicts)
          mismatch($sformatf("evict_total %0d, want %0d", evict_total_o, due.evicts));
      end
    end
  end

  // Stimulus: reset, directed script, then random phases with varying geometry.
  initial begin
    result_t given;
    logic [ADDR_W-1:0] tag_pool [TAG_POOL];
    logic [ADDR_W-1:0] a;
    logic [CFG_DATA_W-1:0] sb_d, bb_d, wy_d;
    int sb, shift;

    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i] = '0;
      shadow_rank[i] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    set_bits_m = '0;
    block_bits_m = '0;
    ways_m = 4'd1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        write_reg(script[i].idx, script[i].data);
      end else begin
        given.outcome = script[i].outcome;
        given.hits = script[i].hits;
        given.misses = script[i].misses;
        given.evicts = script[i].evicts;
        send_access(script[i].op, script[i].addr, script[i].typed, given);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // Geometry of this phase: a mid-size one, the extremes, then random ones.
      case (p)
        0: begin sb_d = 6'd3; bb_d = 6'd6; wy_d = 6'd4; end
        1: begin sb_d = '1; bb_d = '1; wy_d = '1; end
        2: begin sb_d = '0; bb_d = '0; wy_d = '0; end
        default: begin
          sb_d = 6'($urandom_range(0, 63));
          bb_d = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, 10))
                                              : 6'($urandom_range(0, 63));
          wy_d = 6'($urandom_range(0, 63));
        end
      endcase
      write_reg(CFG_SET_BITS, sb_d);
      write_reg(CFG_BLOCK_BITS, bb_d);
      write_reg(CFG_WAYS, wy_d);

      // A few small tags and some wide ones, so sets see hits, fills and evictions.
      for (int i = 0; i < TAG_POOL; i++)
        tag_pool[i] = (i < 4) ? 64'(i) : {$urandom, $urandom};
      quiet = (p == 0);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 3 && n == 20) hold_req = 1'b1;
        if (p == 5 && n == 50) settle();
        if ($urandom_range(0, 99) < 15) begin
          a = {$urandom, $urandom};
        end else begin
          sb = sets_log2_in_use();
          shift = sb + int'(block_bits_m);
          a = (tag_pool[$urandom_range(0, TAG_POOL - 1)] << shift)
            | ((64'($urandom_range(0, 3)) & ((64'd1 << sb) - 64'd1)) << block_bits_m)
            | ({$urandom, $urandom} & ((64'd1 << block_bits_m) - 64'd1));
        end
        given = '0;
        send_access(2'($urandom_range(0, 3)), a, 1'b0, given);
      end
      quiet = 1'b0;
    end

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[set_assoc_cache_lru_sim] OK");
    end else begin
      $display("[set_assoc_cache_lru_sim] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3_000_000;
    $display("[set_assoc_cache_lru_sim] ERROR");
    $finish;
  end

endmodule
